// ===== hdl/six_register_machine_execute_defines.svh =====
// Assertion macros used by the back end of the six-register machine RTL.
`ifndef SIX_REGISTER_MACHINE_EXECUTE_DEFINES_SVH
`define SIX_REGISTER_MACHINE_EXECUTE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SIXRM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SIXRM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sixrm_pkg.sv =====
// Shared types, constants and helper functions of the six-register machine.
`timescale 1ns / 1ps
package sixrm_pkg;

    localparam int NUM_REGS_DEF = 6;
    localparam int IDX_W        = 4;   // register index width, covers up to 16 registers
    localparam int DATA_W       = 32;
    localparam int LEN_W        = 17;
    localparam int BIND_W       = 3;
    localparam int FUNC_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 2;

    // Opcodes
    typedef enum logic [FUNC_W-1:0] {
        F_ADDR = 4'd0,  F_ADDI = 4'd1,  F_MULR = 4'd2,  F_MULI = 4'd3,
        F_BANR = 4'd4,  F_BANI = 4'd5,  F_BORR = 4'd6,  F_BORI = 4'd7,
        F_SETR = 4'd8,  F_SETI = 4'd9,  F_GTIR = 4'd10, F_GTRI = 4'd11,
        F_GTRR = 4'd12, F_EQIR = 4'd13, F_EQRI = 4'd14, F_EQRR = 4'd15
    } t_func;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IP_BINDING     = 2'd0,
        CFG_PROGRAM_LENGTH = 2'd1
    } t_cfg_idx;

    // Classified instruction as it travels from the front to the back
    typedef struct packed {
        t_func               func;
        logic                fault;
        logic                a_reg;
        logic                b_reg;
        logic [IDX_W-1:0]    a_idx;
        logic [IDX_W-1:0]    b_idx;
        logic [IDX_W-1:0]    d_idx;
        logic [DATA_W-1:0]   imm_a;
        logic [DATA_W-1:0]   imm_b;
    } t_op;

    // bit 0: operand A is a register, bit 1: operand B is a register
    function automatic logic [1:0] operand_kind(t_func f);
        logic [1:0] k;
        case (f)
            F_ADDR, F_MULR, F_BANR, F_BORR, F_GTRR, F_EQRR: k = 2'b11;
            F_ADDI, F_MULI, F_BANI, F_BORI, F_SETR, F_GTRI, F_EQRI: k = 2'b01;
            F_GTIR, F_EQIR: k = 2'b10;
            F_SETI: k = 2'b00;
            default: k = 2'b00;
        endcase
        return k;
    endfunction

    // Pointer outside [0, len) halts
    function automatic logic halt_test(logic [DATA_W-1:0] p, logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] len_x;
        len_x = DATA_W'(len);
        return p[DATA_W-1] || (p >= len_x);
    endfunction

endpackage

// ===== hdl/sixrm_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module sixrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== hdl/sixrm_front.sv =====
// Front end: takes instructions and classifies operands and index faults.
`timescale 1ns / 1ps
module sixrm_front #(
    parameter int NUM_REGS = sixrm_pkg::NUM_REGS_DEF
) (
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic        [sixrm_pkg::FUNC_W-1:0]  i_func,
    input  logic signed [sixrm_pkg::DATA_W-1:0]  i_operand_a,
    input  logic signed [sixrm_pkg::DATA_W-1:0]  i_operand_b,
    input  logic        [sixrm_pkg::FUNC_W-1:0]  i_dest,
    input  logic        [sixrm_pkg::BIND_W-1:0]  i_bind,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output sixrm_pkg::t_op                       o_op
);

    import sixrm_pkg::*;

    localparam logic [DATA_W-1:0] NREG = DATA_W'(NUM_REGS);

    logic [1:0]  kind;
    logic        a_bad;
    logic        b_bad;
    logic        d_bad;
    logic        bind_bad;
    t_func       func;

    // Transfer whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Register index checks: negative operands compare as huge unsigned values
    always_comb begin
        func     = t_func'(i_func);
        kind     = operand_kind(func);
        a_bad    = kind[0] && ($unsigned(i_operand_a) >= NREG);
        b_bad    = kind[1] && ($unsigned(i_operand_b) >= NREG);
        d_bad    = DATA_W'(i_dest) >= NREG;
        bind_bad = DATA_W'(i_bind) >= NREG;

        o_op.func  = func;
        o_op.fault = a_bad || b_bad || d_bad || bind_bad;
        o_op.a_reg = kind[0];
        o_op.b_reg = kind[1];
        o_op.a_idx = i_operand_a[IDX_W-1:0];
        o_op.b_idx = i_operand_b[IDX_W-1:0];
        o_op.d_idx = IDX_W'(i_dest);
        o_op.imm_a = $unsigned(i_operand_a);
        o_op.imm_b = $unsigned(i_operand_b);
    end

endmodule

// ===== hdl/sixrm_queue.sv =====
// Short instruction queue between the front and the back.
`timescale 1ns / 1ps
module sixrm_queue #(
    parameter int DEPTH = sixrm_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sixrm_pkg::t_op  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_vld,
    output sixrm_pkg::t_op  o_data
);

    import sixrm_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_cnt;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/sixrm_back.sv =====
// Back end: register file read, execute, write back and result register.
`timescale 1ns / 1ps
`include "six_register_machine_execute_defines.svh"
module sixrm_back #(
    parameter int NUM_REGS = sixrm_pkg::NUM_REGS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_vld,
    input  sixrm_pkg::t_op                       i_q_op,
    output logic                                 o_q_pop,
    input  logic        [sixrm_pkg::BIND_W-1:0]  i_bind,
    input  logic        [sixrm_pkg::LEN_W-1:0]   i_len,
    input  logic                                 i_flush,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [sixrm_pkg::DATA_W-1:0]  o_next_ip,
    output logic signed [sixrm_pkg::DATA_W-1:0]  o_written_value,
    output logic signed [sixrm_pkg::DATA_W-1:0]  o_reg_zero,
    output logic                                 o_halted,
    output logic                                 o_fault
);

    import sixrm_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    // Pipeline control
    logic              out_free;
    logic              s1_adv;
    logic              s2_exec;
    logic              r_s2_vld;
    t_op               r_s2_op;

    // Architectural state; the bound register is mirrored by r_ip - 1
    logic [DATA_W-1:0] r_ip;
    logic [DATA_W-1:0] r_reg0;
    logic              r_mir_vld;
    logic [NUM_REGS-1:0] r_ent_vld;

    // Last write, forwarded over the registered RAM read
    logic              r_fwd_vld;
    logic [IDX_W-1:0]  r_fwd_idx;
    logic [DATA_W-1:0] r_fwd_val;

    // Write port
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] wr_val;

    // Execute datapath
    logic [IDX_W-1:0]  bind_idx;
    logic [DATA_W-1:0] ram_a;
    logic [DATA_W-1:0] ram_b;
    logic [DATA_W-1:0] reg_a;
    logic [DATA_W-1:0] reg_b;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] nxt;
    logic [DATA_W-1:0] new_reg0;

    // Result register
    logic              r_out_vld;
    logic [DATA_W-1:0] r_nip;
    logic [DATA_W-1:0] r_wval;
    logic [DATA_W-1:0] r_reg0o;
    logic              r_halt;
    logic              r_fault;

    assign out_free = !r_out_vld || i_out_ready;
    assign s2_exec  = r_s2_vld && out_free;
    assign s1_adv   = i_q_vld && (!r_s2_vld || out_free);
    assign o_q_pop  = s1_adv;
    assign bind_idx = IDX_W'(i_bind);

    sixrm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_rf (
        .i_clk    (i_clk),
        .i_we     (wr_en),
        .i_waddr  (wr_idx[AW-1:0]),
        .i_wdata  (wr_val),
        .i_re     (s1_adv),
        .i_raddr0 (i_q_op.a_idx[AW-1:0]),
        .i_raddr1 (i_q_op.b_idx[AW-1:0]),
        .o_rdata0 (ram_a),
        .o_rdata1 (ram_b)
    );

    // Operand fetch: bound register, then last write, then RAM, unwritten reads zero
    always_comb begin
        if (r_s2_op.a_idx == bind_idx) begin
            reg_a = r_ip;
        end else if (r_fwd_vld && (r_s2_op.a_idx == r_fwd_idx)) begin
            reg_a = r_fwd_val;
        end else if (r_ent_vld[r_s2_op.a_idx[AW-1:0]]) begin
            reg_a = ram_a;
        end else begin
            reg_a = '0;
        end
        if (r_s2_op.b_idx == bind_idx) begin
            reg_b = r_ip;
        end else if (r_fwd_vld && (r_s2_op.b_idx == r_fwd_idx)) begin
            reg_b = r_fwd_val;
        end else if (r_ent_vld[r_s2_op.b_idx[AW-1:0]]) begin
            reg_b = ram_b;
        end else begin
            reg_b = '0;
        end
        opa = r_s2_op.a_reg ? reg_a : r_s2_op.imm_a;
        opb = r_s2_op.b_reg ? reg_b : r_s2_op.imm_b;
    end

    // ALU, 32-bit wrap, signed compares
    always_comb begin
        case (r_s2_op.func)
            F_ADDR, F_ADDI: val = opa + opb;
            F_MULR, F_MULI: val = opa * opb;
            F_BANR, F_BANI: val = opa & opb;
            F_BORR, F_BORI: val = opa | opb;
            F_SETR, F_SETI: val = opa;
            F_GTIR, F_GTRI, F_GTRR: val = DATA_W'($signed(opa) > $signed(opb));
            F_EQIR, F_EQRI, F_EQRR: val = DATA_W'(opa == opb);
            default: val = '0;
        endcase
        nxt = (r_s2_op.d_idx == bind_idx) ? val + 1'b1 : r_ip + 1'b1;
        if (r_s2_op.d_idx == '0) begin
            new_reg0 = val;
        end else if (bind_idx == '0) begin
            new_reg0 = r_ip;
        end else begin
            new_reg0 = r_reg0;
        end
    end

    // Write port: execution, or materializing the old bound register on a rebind
    always_comb begin
        if (s2_exec && !r_s2_op.fault) begin
            wr_en  = 1'b1;
            wr_idx = r_s2_op.d_idx;
            wr_val = val;
        end else begin
            wr_en  = i_flush && r_mir_vld;
            wr_idx = bind_idx;
            wr_val = r_ip - 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ip      <= '0;
            r_reg0    <= '0;
            r_mir_vld <= 1'b0;
            r_ent_vld <= '0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s2_vld <= 1'b1;
            end else if (s2_exec) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_exec) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (s2_exec && !r_s2_op.fault) begin
                r_ip      <= nxt;
                r_reg0    <= new_reg0;
                r_mir_vld <= 1'b1;
            end else if (i_flush) begin
                r_mir_vld <= 1'b0;
            end
            if (wr_en) begin
                r_ent_vld[wr_idx[AW-1:0]] <= 1'b1;
                r_fwd_vld <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_op <= i_q_op;
        end
        if (wr_en) begin
            r_fwd_idx <= wr_idx;
            r_fwd_val <= wr_val;
        end
        if (s2_exec) begin
            if (r_s2_op.fault) begin
                r_nip   <= r_ip;
                r_wval  <= '0;
                r_reg0o <= r_reg0;
                r_halt  <= halt_test(r_ip, i_len);
                r_fault <= 1'b1;
            end else begin
                r_nip   <= nxt;
                r_wval  <= val;
                r_reg0o <= new_reg0;
                r_halt  <= halt_test(nxt, i_len);
                r_fault <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_next_ip       = $signed(r_nip);
    assign o_written_value = $signed(r_wval);
    assign o_reg_zero      = $signed(r_reg0o);
    assign o_halted        = r_halt;
    assign o_fault         = r_fault;

    // Checks
    `SIXRM_ASSERT_NXT(a_fault_keeps_ip, s2_exec && r_s2_op.fault && !i_flush, $stable(r_ip), "fault changed the pointer")
    `SIXRM_ASSERT_NXT(a_exec_sets_mirror, s2_exec && !r_s2_op.fault, r_mir_vld, "mirror not set after execution")
    `SIXRM_ASSERT_IMP(a_write_source, wr_en, s2_exec || i_flush, "register write without a source")
    `SIXRM_ASSERT_IMP(a_fault_zero_value, r_out_vld && r_fault, r_wval == '0, "faulted result carries a value")

endmodule

// ===== hdl/six_register_machine_execute.sv =====
// Top level of the six-register machine: configuration, front, queue and back.
`timescale 1ns / 1ps
// Executes one instruction per input transfer on a small register machine whose
// instruction pointer is bound to a configurable register.
// Channels:
//   in  : i_in_valid/o_in_ready with func, operand_a, operand_b, dest.
//   out : o_out_valid/i_out_ready with next_ip, written_value, reg_zero,
//         halted and fault; exactly one result per instruction, in order.
//   cfg : i_cfg_valid/o_cfg_ready with i_cfg_index/i_cfg_data; index 0 sets
//         ip_binding, index 1 sets program_length, other indexes are dropped.
//         Write configuration only while no instruction is in flight.
// Pipeline: an input transfer is registered in the queue, read from the register
//   file into the execute stage, then executed into the result register.
// Throughput: one instruction per cycle while the receiver takes results; the
//   execute stage closes the register-file and pointer feedback without stalling.
// Reset: registers, pointer and configuration clear to zero; the block is
//   ready as soon as reset is released.
// Receiver stall: the result register holds, the execute stage and queue fill,
//   then o_in_ready drops until the receiver takes results again.
module six_register_machine_execute #(
    parameter int NUM_REGS = sixrm_pkg::NUM_REGS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic        [sixrm_pkg::FUNC_W-1:0]     i_func,
    input  logic signed [sixrm_pkg::DATA_W-1:0]     i_operand_a,
    input  logic signed [sixrm_pkg::DATA_W-1:0]     i_operand_b,
    input  logic        [sixrm_pkg::FUNC_W-1:0]     i_dest,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [sixrm_pkg::DATA_W-1:0]     o_next_ip,
    output logic signed [sixrm_pkg::DATA_W-1:0]     o_written_value,
    output logic signed [sixrm_pkg::DATA_W-1:0]     o_reg_zero,
    output logic                                    o_halted,
    output logic                                    o_fault,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic        [sixrm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [sixrm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import sixrm_pkg::*;

    logic [BIND_W-1:0] r_bind;
    logic [LEN_W-1:0]  r_len;
    logic              cfg_we;
    logic              flush;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_vld;
    t_op               fr_op;
    t_op               q_op;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign flush       = cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_IP_BINDING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bind <= '0;
            r_len  <= '0;
        end else if (cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IP_BINDING:     r_bind <= i_cfg_data[BIND_W-1:0];
                CFG_PROGRAM_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    sixrm_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_dest      (i_dest),
        .i_bind      (r_bind),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_op        (fr_op)
    );

    sixrm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (fr_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_op)
    );

    sixrm_back #(
        .NUM_REGS (NUM_REGS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (q_vld),
        .i_q_op          (q_op),
        .o_q_pop         (q_pop),
        .i_bind          (r_bind),
        .i_len           (r_len),
        .i_flush         (flush),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_next_ip       (o_next_ip),
        .o_written_value (o_written_value),
        .o_reg_zero      (o_reg_zero),
        .o_halted        (o_halted),
        .o_fault         (o_fault)
    );

endmodule
